// File: rtl/tmde_pkg.sv
// Shared types and constants of the trigonometric mutation block.
// Used by the register bank, the controller, the datapath and the top level.
`default_nettype none

package tmde_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Quotient bits produced per cycle by the divide-by-three unit.
  localparam int unsigned DIGIT_BITS = 8;

  // Number of weighted difference terms summed per element.
  localparam int unsigned MUL_TERMS = 3;

  // Request kinds carried in tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ELEM = 1'b1;

  // Register indexes.
  localparam logic REG_CLAMP_LOW  = 1'b0;
  localparam logic REG_CLAMP_HIGH = 1'b1;

  // Parent selectors.
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic       capture;
    logic       prep;
    logic       div_start;
    logic       div_step;
    logic       div_first;
    logic [1:0] div_sel;
    logic       wt_write;
    logic [1:0] wt_sel;
    logic       wt_zero;
    logic       mean_step;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_add;
    logic       fin_sum;
    logic       out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cmd;
    logic sum_zero;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/trigonometric_mutation_de.sv
// Trigonometric mutation for differential evolution, fixed point.
// Element request: the divide-by-three unit (8 quotient bits a cycle) sets the element time;
//   a new request is taken only once the previous result has been loaded into the output register.
// Load request: the three weights are divided in turn, and skipped when the sum is zero;
//   one shared restoring divider makes one weight bit a cycle.
// Synchronous active-low reset clears weights, flag and control; clamps take full range.
`default_nettype none

module trigonometric_mutation_de #(
  parameter int unsigned DATA_WIDTH = tmde_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = tmde_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W      = ((6 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned APB_W     = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int unsigned ADDR_W    = (DATA_WIDTH > 32) ? 4 : 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // fitness_a, fitness_b, fitness_c, value_a, value_b, value_c, zero padding
  input  wire logic [IN_W-1:0]   in_tdata,
  // command
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // mutant, zero padding
  output logic [OUT_W-1:0]       out_tdata,
  // zero_sum
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_W-1:0]  cfg_pwdata,
  output logic      [APB_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned DW = DATA_WIDTH;

  tmde_pkg::cmd_t  cmd;
  tmde_pkg::stat_t stat;

  logic signed [DW-1:0] clamp_low, clamp_high;
  logic [DW-1:0]        mutant;

  assign cfg_pready = 1'b1;

  tmde_regs #(
    .DATA_WIDTH (DATA_WIDTH),
    .APB_W      (APB_W),
    .ADDR_W     (ADDR_W)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .clamp_low  (clamp_low),
    .clamp_high (clamp_high)
  );

  tmde_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  tmde_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_last    (in_tlast),
    .fit_a      (in_tdata[DW-1:0]),
    .fit_b      (in_tdata[2*DW-1:DW]),
    .fit_c      (in_tdata[3*DW-1:2*DW]),
    .val_a      (in_tdata[4*DW-1:3*DW]),
    .val_b      (in_tdata[5*DW-1:4*DW]),
    .val_c      (in_tdata[6*DW-1:5*DW]),
    .clamp_low  (clamp_low),
    .clamp_high (clamp_high),
    .mutant     (mutant),
    .last_out   (out_tlast),
    .zero_sum   (out_tuser)
  );

  assign out_tdata = OUT_W'(mutant);

endmodule

`default_nettype wire

// File: rtl/tmde_regs.sv
// APB register bank holding the two clamp bounds.
// Depends on tmde_pkg for the register indexes.
`default_nettype none

module tmde_regs #(
  parameter int unsigned DATA_WIDTH = tmde_pkg::DATA_WIDTH_DEF,
  parameter int unsigned APB_W      = 32,
  parameter int unsigned ADDR_W     = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_W-1:0]            paddr,
  input  wire logic [APB_W-1:0]             pwdata,
  output logic      [APB_W-1:0]             prdata,
  output logic signed [DATA_WIDTH-1:0]      clamp_low,
  output logic signed [DATA_WIDTH-1:0]      clamp_high
);

  logic signed [DATA_WIDTH-1:0] clamp_low_r, clamp_low_nxt;
  logic signed [DATA_WIDTH-1:0] clamp_high_r, clamp_high_nxt;
  logic                         wr_en;
  logic                         idx;

  // The register index is the address bit just above the byte offset.
  assign idx   = paddr[ADDR_W-1];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    clamp_low_nxt  = clamp_low_r;
    clamp_high_nxt = clamp_high_r;
    if (wr_en) begin
      unique case (idx)
        tmde_pkg::REG_CLAMP_LOW:  clamp_low_nxt  = pwdata[DATA_WIDTH-1:0];
        tmde_pkg::REG_CLAMP_HIGH: clamp_high_nxt = pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      clamp_high_r <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      clamp_low_r  <= clamp_low_nxt;
      clamp_high_r <= clamp_high_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      tmde_pkg::REG_CLAMP_LOW:  prdata = APB_W'(clamp_low_r);
      tmde_pkg::REG_CLAMP_HIGH: prdata = APB_W'(clamp_high_r);
      default:                  prdata = '0;
    endcase
  end

  assign clamp_low  = clamp_low_r;
  assign clamp_high = clamp_high_r;

endmodule

`default_nettype wire

// File: rtl/tmde_ctrl.sv
// Controller of the trigonometric mutation block: sequences loads, the
// weight divisions and the element arithmetic. Depends on tmde_pkg.
`default_nettype none

module tmde_ctrl #(
  parameter int unsigned DATA_WIDTH = tmde_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = tmde_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output tmde_pkg::cmd_t       cmd,
  input  wire tmde_pkg::stat_t stat
);

  localparam int unsigned MSTEPS = (DATA_WIDTH + 2 + tmde_pkg::DIGIT_BITS - 1) /
                                   tmde_pkg::DIGIT_BITS;
  localparam int unsigned E_CNT  = (MSTEPS > tmde_pkg::MUL_TERMS + 1) ?
                                   MSTEPS : tmde_pkg::MUL_TERMS + 1;
  localparam int unsigned E_LAST = E_CNT - 1;
  localparam int unsigned CNT_MAX = (FRAC_BITS > E_LAST) ? FRAC_BITS : E_LAST;
  localparam int unsigned CNT_W  = $clog2(CNT_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_ELEM = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    in_tready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
        if (stat.cmd == tmde_pkg::CMD_LOAD) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_ELEM;
        end
      end
      S_CHK: begin
        if (stat.sum_zero) begin
          cmd.wt_zero = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tmde_pkg::SEL_A;
          sel_nxt       = tmde_pkg::SEL_A;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          cnt_nxt   = '0;
          state_nxt = S_WR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WR: begin
        cmd.wt_write = 1'b1;
        cmd.wt_sel   = sel_r;
        if (sel_r == tmde_pkg::SEL_C) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = sel_r + 2'd1;
          sel_nxt       = sel_r + 2'd1;
          state_nxt     = S_DIV;
        end
      end
      S_ELEM: begin
        // The divide-by-three digits and the three products share these cycles;
        // each product is accumulated in the cycle after it is registered.
        cmd.mean_step = (cnt_r < CNT_W'(MSTEPS));
        cmd.mul_en    = (cnt_r < CNT_W'(tmde_pkg::MUL_TERMS));
        cmd.mul_sel   = cnt_r[1:0];
        cmd.acc_add   = (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(tmde_pkg::MUL_TERMS));
        if (cnt_r == CNT_W'(E_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = S_SUM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SUM: begin
        cmd.fin_sum = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= tmde_pkg::SEL_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/tmde_dp.sv
// Datapath of the trigonometric mutation block: weight divider, stored
// weights, divide-by-three unit, shared multiplier, accumulator and clamp.
// Depends on tmde_pkg for the command and status structs.
`default_nettype none

module tmde_dp #(
  parameter int unsigned DATA_WIDTH = tmde_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = tmde_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tmde_pkg::cmd_t          cmd,
  output tmde_pkg::stat_t              stat,
  input  wire logic                    in_cmd,
  input  wire logic                    in_last,
  input  wire logic signed [DATA_WIDTH-1:0] fit_a,
  input  wire logic signed [DATA_WIDTH-1:0] fit_b,
  input  wire logic signed [DATA_WIDTH-1:0] fit_c,
  input  wire logic signed [DATA_WIDTH-1:0] val_a,
  input  wire logic signed [DATA_WIDTH-1:0] val_b,
  input  wire logic signed [DATA_WIDTH-1:0] val_c,
  input  wire logic signed [DATA_WIDTH-1:0] clamp_low,
  input  wire logic signed [DATA_WIDTH-1:0] clamp_high,
  output logic [DATA_WIDTH-1:0]        mutant,
  output logic                         last_out,
  output logic                         zero_sum
);

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned WW     = FRAC_BITS + 2;
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned MW     = DW + 2;
  localparam int unsigned RMW    = DW + 3;
  localparam int unsigned DB     = tmde_pkg::DIGIT_BITS;
  localparam int unsigned MSTEPS = (MW + DB - 1) / DB;
  localparam int unsigned MPW    = MSTEPS * DB;
  localparam int unsigned VDW    = DW + 1;
  localparam int unsigned WDW    = WW + 1;
  localparam int unsigned PW     = VDW + WDW;
  localparam int unsigned ACCW   = PW + 2;
  localparam int unsigned RW     = ACCW - FRAC_BITS + 1;

  // Captured request.
  logic                 cmd_r, last_r;
  logic [DW-1:0]        mag_a_r, mag_b_r, mag_c_r;
  logic                 neg_a_r, neg_b_r, neg_c_r;
  logic signed [DW-1:0] val_a_r, val_b_r, val_c_r;

  // Weight divider.
  logic [MW-1:0]  sum_r;
  logic [RMW-1:0] rem_div_r;
  logic [QW-1:0]  quo_r;
  logic [DW-1:0]  div_mag;
  logic [RMW-1:0] cand;
  logic [RMW-1:0] cand_diff;
  logic           cand_ge;

  // Stored weights and zero-sum flag.
  logic signed [WW-1:0] w_a_r, w_b_r, w_c_r;
  logic                 flag_r;
  logic signed [WW-1:0] w_mag;
  logic signed [WW-1:0] w_val;
  logic                 w_neg;

  // Divide-by-three unit.
  logic signed [MW-1:0] s_sum;
  logic [MW-1:0]        s_mag;
  logic                 s_neg_r;
  logic [MPW-1:0]       mshift_r;
  logic [1:0]           rem3_r;
  logic [1:0]           rem3;
  logic [2:0]           rem3_t;
  logic [DB-1:0]        qdig;

  // Products and accumulation.
  logic signed [WDW-1:0]  wd;
  logic signed [VDW-1:0]  vd;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;

  // Final sum and clamp.
  logic [MW-1:0]        mean_q;
  logic signed [MW:0]   mean_s;
  logic signed [RW-1:0] v_r;
  logic signed [RW-1:0] lo, hi, t1, t2;
  logic [DW-1:0]        mutant_r;
  logic                 last_out_r, zero_out_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      last_r  <= in_last;
      mag_a_r <= fit_a[DW-1] ? DW'(-fit_a) : DW'(fit_a);
      mag_b_r <= fit_b[DW-1] ? DW'(-fit_b) : DW'(fit_b);
      mag_c_r <= fit_c[DW-1] ? DW'(-fit_c) : DW'(fit_c);
      neg_a_r <= fit_a[DW-1];
      neg_b_r <= fit_b[DW-1];
      neg_c_r <= fit_c[DW-1];
      val_a_r <= val_a;
      val_b_r <= val_b;
      val_c_r <= val_c;
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.sum_zero = (sum_r == '0);

  // Weight divider: restoring long division of |f| * 2^FRAC_BITS by the sum.
  // The first step compares without shifting, giving the integer bit.
  always_comb begin
    case (cmd.div_sel)
      tmde_pkg::SEL_A: div_mag = mag_a_r;
      tmde_pkg::SEL_B: div_mag = mag_b_r;
      default:         div_mag = mag_c_r;
    endcase
    cand      = cmd.div_first ? rem_div_r : {rem_div_r[RMW-2:0], 1'b0};
    cand_ge   = (cand >= RMW'(sum_r));
    cand_diff = cand - RMW'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sum_r <= MW'(mag_a_r) + MW'(mag_b_r) + MW'(mag_c_r);
    end
    if (cmd.div_start) begin
      rem_div_r <= RMW'(div_mag);
      quo_r     <= '0;
    end else if (cmd.div_step) begin
      rem_div_r <= cand_ge ? cand_diff : cand;
      quo_r     <= {quo_r[QW-2:0], cand_ge};
    end
  end

  always_comb begin
    case (cmd.wt_sel)
      tmde_pkg::SEL_A: w_neg = neg_a_r;
      tmde_pkg::SEL_B: w_neg = neg_b_r;
      default:         w_neg = neg_c_r;
    endcase
    w_mag = signed'({1'b0, quo_r});
    w_val = w_neg ? -w_mag : w_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_a_r  <= '0;
      w_b_r  <= '0;
      w_c_r  <= '0;
      flag_r <= 1'b0;
    end else if (cmd.wt_zero) begin
      w_a_r  <= '0;
      w_b_r  <= '0;
      w_c_r  <= '0;
      flag_r <= 1'b1;
    end else if (cmd.wt_write) begin
      flag_r <= 1'b0;
      case (cmd.wt_sel)
        tmde_pkg::SEL_A: w_a_r <= w_val;
        tmde_pkg::SEL_B: w_b_r <= w_val;
        default:         w_c_r <= w_val;
      endcase
    end
  end

  // Divide-by-three: the magnitude of a+b+c is shifted out MSB first, one
  // digit per step, and the quotient bits are shifted in behind it.
  always_comb begin
    s_sum = MW'(val_a_r) + MW'(val_b_r) + MW'(val_c_r);
    s_mag = s_sum[MW-1] ? MW'(-s_sum) : MW'(s_sum);
    rem3  = rem3_r;
    qdig  = '0;
    for (int i = 0; i < DB; i++) begin
      rem3_t = {rem3, mshift_r[MPW-1-i]};
      if (rem3_t >= 3'd3) begin
        rem3         = 2'(rem3_t - 3'd3);
        qdig[DB-1-i] = 1'b1;
      end else begin
        rem3 = rem3_t[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      s_neg_r  <= s_sum[MW-1];
      mshift_r <= MPW'(s_mag);
      rem3_r   <= '0;
    end else if (cmd.mean_step) begin
      mshift_r <= {mshift_r[MPW-DB-1:0], qdig};
      rem3_r   <= rem3;
    end
  end

  // One shared multiplier forms the three weighted differences in turn.
  always_comb begin
    case (cmd.mul_sel)
      tmde_pkg::SEL_A: begin
        wd = WDW'(w_b_r) - WDW'(w_a_r);
        vd = VDW'(val_a_r) - VDW'(val_b_r);
      end
      tmde_pkg::SEL_B: begin
        wd = WDW'(w_c_r) - WDW'(w_b_r);
        vd = VDW'(val_b_r) - VDW'(val_c_r);
      end
      default: begin
        wd = WDW'(w_a_r) - WDW'(w_c_r);
        vd = VDW'(val_c_r) - VDW'(val_a_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= wd * vd;
    end
    if (cmd.prep) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
  end

  // The arithmetic shift of the accumulator rounds toward minus infinity.
  always_comb begin
    mean_q = mshift_r[MW-1:0];
    mean_s = s_neg_r ? -signed'({1'b0, mean_q}) : signed'({1'b0, mean_q});
    lo     = RW'(clamp_low);
    hi     = RW'(clamp_high);
    t1     = (v_r < lo) ? lo : v_r;
    t2     = (t1 > hi) ? hi : t1;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_sum) begin
      v_r <= RW'(mean_s) + RW'(acc_r >>> FRAC_BITS);
    end
    if (cmd.out_load) begin
      mutant_r   <= t2[DW-1:0];
      last_out_r <= last_r;
      zero_out_r <= flag_r;
    end
  end

  assign mutant   = mutant_r;
  assign last_out = last_out_r;
  assign zero_sum = zero_out_r;

endmodule

`default_nettype wire
